// ===== hdl/sdgq_pkg.sv =====
// ----------------------------------------------------------------------------
// sdgq_pkg: shared types and constants
// Field widths, reset values and chain control types for the grant queue.
// ----------------------------------------------------------------------------
`default_nettype none
package sdgq_pkg;

  localparam int DL_DEPTH_DEF = 16;
  localparam int UL_DEPTH_DEF = 8;
  localparam int MAX_RESULTS  = 16;

  localparam int SLOT_W = 20;
  localparam int RNTI_W = 16;
  localparam int PRB_W  = 9;
  localparam int MCS_W  = 5;
  localparam int INFO_W = 32;
  localparam int KIND_W = 2;
  localparam int MAXC_W = 5;

  // downlink entry: kind, slot, rnti, prb_first, prb_count, mcs
  localparam int DL_W = KIND_W + SLOT_W + RNTI_W + PRB_W + PRB_W + MCS_W;
  // uplink entry: slot, info
  localparam int UL_W = SLOT_W + INFO_W;

  localparam logic [PRB_W-1:0] RAR_PRB_FIRST_RST  = 9'd44;
  localparam logic [PRB_W-1:0] RAR_PRB_COUNT_RST  = 9'd12;
  localparam logic [PRB_W-1:0] MSG4_PRB_FIRST_RST = 9'd48;
  localparam logic [PRB_W-1:0] MSG4_PRB_COUNT_RST = 9'd16;
  localparam logic [MCS_W-1:0] GRANT_MCS_RST      = 5'd4;

  typedef enum logic [1:0] {
    ACT_QUEUE_RAR  = 2'd0,
    ACT_QUEUE_MSG4 = 2'd1,
    ACT_POP_DL     = 2'd2,
    ACT_POP_UL     = 2'd3
  } action_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_STATUS = 2'd0,
    KIND_RAR    = 2'd1,
    KIND_MSG4   = 2'd2,
    KIND_MSG3   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_RAR_PRB_FIRST  = 3'd0,
    REG_RAR_PRB_COUNT  = 3'd1,
    REG_MSG4_PRB_FIRST = 3'd2,
    REG_MSG4_PRB_COUNT = 3'd3,
    REG_GRANT_MCS      = 3'd4
  } reg_idx_t;

  // chain control: append, take head, take head and re-append at tail
  typedef struct packed {
    logic push;
    logic pop;
    logic keep;
  } chain_ctl_t;

  // per-cell control
  typedef struct packed {
    logic write;
    logic shift;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/sdgq_cell.sv =====
// ----------------------------------------------------------------------------
// sdgq_cell: one table cell
// Holds one entry; loads new data, takes its neighbor's entry, or holds.
// ----------------------------------------------------------------------------
`default_nettype none
module sdgq_cell
  import sdgq_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire cell_ctl_t        ctl,
  input  wire logic [WIDTH-1:0] din,
  input  wire logic [WIDTH-1:0] nbr,
  output logic      [WIDTH-1:0] q
);

  always_ff @(posedge clk) begin
    if (ctl.write) begin
      q <= din;
    end else if (ctl.shift) begin
      q <= nbr;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sdgq_chain.sv =====
// ----------------------------------------------------------------------------
// sdgq_chain: ordered table as a row of cells
// Entries sit at cells 0..cnt-1; a pop shifts toward cell 0, a kept head
// goes back in at the tail.
// ----------------------------------------------------------------------------
`default_nettype none
module sdgq_chain
  import sdgq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire chain_ctl_t       ctl,
  input  wire logic [WIDTH-1:0] din,
  output logic      [WIDTH-1:0] head,
  output logic      [CW-1:0]    cnt,
  output logic                  full
);

  logic [WIDTH-1:0] q [DEPTH];
  logic [CW-1:0]    tail;

  assign head = q[0];
  assign full = (cnt == CW'(DEPTH));
  assign tail = cnt - CW'(1);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t        cc;
    logic [WIDTH-1:0] cd;
    logic [WIDTH-1:0] nb;

    always_comb begin
      cc.shift = ctl.pop;
      cc.write = (ctl.push && cnt == CW'(i)) ||
                 (ctl.pop && ctl.keep && tail == CW'(i));
      cd = ctl.push ? din : q[0];
    end

    if (i == DEPTH - 1) begin : g_end
      assign nb = q[i];
    end else begin : g_mid
      assign nb = q[i+1];
    end

    sdgq_cell #(.WIDTH(WIDTH)) u_cell (
      .clk (clk),
      .ctl (cc),
      .din (cd),
      .nbr (nb),
      .q   (q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.push) begin
      cnt <= cnt + CW'(1);
    end else if (ctl.pop && !ctl.keep) begin
      cnt <= cnt - CW'(1);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/slot_due_grant_queue.sv =====
// ----------------------------------------------------------------------------
// slot_due_grant_queue: slot-tagged pending grant queue
// Two ordered tables (downlink grants, Msg3 uplink grants) built as cell
// chains. Queue requests append; pop requests scan, emit due grants, compact.
// ----------------------------------------------------------------------------
// A queue request moves to S_REPLY, where its status is registered once the
// output is free. A pop walks its table one entry a cycle through the chain
// head, unless a due entry waits on a stalled output; it then passes S_FINISH,
// which registers its final result. A new request is taken only in S_IDLE,
// once the previous one is through. The output register lets the next
// request be accepted while the final result still waits.
// Reset (rst, synchronous) empties both tables and reloads the registers.
// ----------------------------------------------------------------------------
`default_nettype none
module slot_due_grant_queue
  import sdgq_pkg::*;
#(
  parameter int DOWNLINK_DEPTH = DL_DEPTH_DEF,
  parameter int UPLINK_DEPTH   = UL_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [PRB_W-1:0]  cfg_data,
  // request channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        action,
  input  wire logic [SLOT_W-1:0] slot,
  input  wire logic [RNTI_W-1:0] rnti,
  input  wire logic [SLOT_W-1:0] msg3_slot,
  input  wire logic [INFO_W-1:0] msg3_info,
  input  wire logic [MAXC_W-1:0] max_count,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [KIND_W-1:0]      kind,
  output logic                   accepted,
  output logic [SLOT_W-1:0]      grant_slot,
  output logic [RNTI_W-1:0]      grant_rnti,
  output logic [PRB_W-1:0]       prb_first,
  output logic [PRB_W-1:0]       prb_count,
  output logic [MCS_W-1:0]       mcs,
  output logic [INFO_W-1:0]      uplink_info,
  output logic                   last
);

  localparam int DCW  = $clog2(DOWNLINK_DEPTH + 1);
  localparam int UCW  = $clog2(UPLINK_DEPTH + 1);
  localparam int MAXD = (DOWNLINK_DEPTH > UPLINK_DEPTH) ? DOWNLINK_DEPTH : UPLINK_DEPTH;
  localparam int SW   = $clog2(MAXD + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_REPLY,
    S_SCAN,
    S_FINISH
  } state_t;

  // one result word, also used for the held-back grant
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [RNTI_W-1:0] rnti;
    logic [PRB_W-1:0]  pf;
    logic [PRB_W-1:0]  pc;
    logic [MCS_W-1:0]  mcs;
    logic [INFO_W-1:0] info;
  } res_t;

  // configuration registers
  logic [PRB_W-1:0] rar_prb_first, rar_prb_count, msg4_prb_first, msg4_prb_count;
  logic [MCS_W-1:0] grant_mcs;

  always_ff @(posedge clk) begin
    if (rst) begin
      rar_prb_first  <= RAR_PRB_FIRST_RST;
      rar_prb_count  <= RAR_PRB_COUNT_RST;
      msg4_prb_first <= MSG4_PRB_FIRST_RST;
      msg4_prb_count <= MSG4_PRB_COUNT_RST;
      grant_mcs      <= GRANT_MCS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RAR_PRB_FIRST:  rar_prb_first  <= cfg_data;
        REG_RAR_PRB_COUNT:  rar_prb_count  <= cfg_data;
        REG_MSG4_PRB_FIRST: msg4_prb_first <= cfg_data;
        REG_MSG4_PRB_COUNT: msg4_prb_count <= cfg_data;
        REG_GRANT_MCS:      grant_mcs      <= cfg_data[MCS_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  state_t            state;
  logic              sel_ul;     // scan works on the uplink table
  logic [SW-1:0]     steps;      // entries left to visit
  logic [MAXC_W-1:0] emitted;
  logic [MAXC_W-1:0] maxc;       // clamped max_count
  logic [SLOT_W-1:0] pop_slot;
  logic              reply_ok;
  logic              pvalid;     // a grant is held until we know if it is last
  res_t              pend;

  // chains
  chain_ctl_t      dl_ctl, ul_ctl;
  logic [DL_W-1:0] dl_din, dl_head;
  logic [UL_W-1:0] ul_din, ul_head;
  logic [DCW-1:0]  dl_cnt;
  logic [UCW-1:0]  ul_cnt;
  logic            dl_full, ul_full;

  sdgq_chain #(.DEPTH(DOWNLINK_DEPTH), .WIDTH(DL_W)) u_dl (
    .clk (clk), .rst (rst), .ctl (dl_ctl), .din (dl_din),
    .head (dl_head), .cnt (dl_cnt), .full (dl_full)
  );

  sdgq_chain #(.DEPTH(UPLINK_DEPTH), .WIDTH(UL_W)) u_ul (
    .clk (clk), .rst (rst), .ctl (ul_ctl), .din (ul_din),
    .head (ul_head), .cnt (ul_cnt), .full (ul_full)
  );

  // request decode
  logic    in_acc;
  action_t act;
  logic    rar_ok, msg4_ok;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign act      = action_t'(action);
  assign rar_ok   = !dl_full && !ul_full;
  assign msg4_ok  = !dl_full;

  // head entry as a result word
  res_t head_res;
  logic head_due;

  always_comb begin
    head_res = '0;
    if (sel_ul) begin
      head_res.kind = KIND_MSG3;
      {head_res.slot, head_res.info} = ul_head;
    end else begin
      {head_res.kind, head_res.slot, head_res.rnti,
       head_res.pf, head_res.pc, head_res.mcs} = dl_head;
    end
  end

  assign head_due = (head_res.slot == pop_slot) && (emitted < maxc);

  // output side
  logic out_free;
  logic scan_step, scan_emit;
  logic out_load;

  assign out_free  = !out_valid || !out_stall;
  // a due entry may only leave when the held grant can go to the output
  assign scan_emit = (state == S_SCAN) && (steps != '0) && head_due &&
                     (!pvalid || out_free);
  assign scan_step = (state == S_SCAN) && (steps != '0) && (!head_due || scan_emit);
  // output register takes a new result this cycle
  assign out_load  = ((state == S_REPLY || state == S_FINISH) && out_free) ||
                     (scan_emit && pvalid);

  always_comb begin
    dl_ctl = '0;
    ul_ctl = '0;
    dl_din = {KIND_MSG4, slot, rnti, msg4_prb_first, msg4_prb_count, grant_mcs};
    ul_din = {msg3_slot, msg3_info};
    if (in_acc && act == ACT_QUEUE_RAR && rar_ok) begin
      dl_din      = {KIND_RAR, slot, rnti, rar_prb_first, rar_prb_count, grant_mcs};
      dl_ctl.push = 1'b1;
      ul_ctl.push = 1'b1;
    end else if (in_acc && act == ACT_QUEUE_MSG4 && msg4_ok) begin
      dl_ctl.push = 1'b1;
    end
    if (scan_step) begin
      if (sel_ul) begin
        ul_ctl.pop  = 1'b1;
        ul_ctl.keep = !scan_emit;
      end else begin
        dl_ctl.pop  = 1'b1;
        dl_ctl.keep = !scan_emit;
      end
    end
  end

  // output valid: set on a load, cleared once the result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pvalid    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            pop_slot <= slot;
            maxc     <= (max_count > MAXC_W'(MAX_RESULTS)) ? MAXC_W'(MAX_RESULTS)
                                                           : max_count;
            emitted  <= '0;
            pvalid   <= 1'b0;
            unique case (act)
              ACT_QUEUE_RAR: begin
                reply_ok <= rar_ok;
                state    <= S_REPLY;
              end
              ACT_QUEUE_MSG4: begin
                reply_ok <= msg4_ok;
                state    <= S_REPLY;
              end
              ACT_POP_DL: begin
                sel_ul <= 1'b0;
                steps  <= SW'(dl_cnt);
                state  <= S_SCAN;
              end
              default: begin
                sel_ul <= 1'b1;
                steps  <= SW'(ul_cnt);
                state  <= S_SCAN;
              end
            endcase
          end
        end
        S_REPLY: begin
          if (out_free) begin
            kind        <= KIND_STATUS;
            accepted    <= reply_ok;
            grant_slot  <= '0;
            grant_rnti  <= '0;
            prb_first   <= '0;
            prb_count   <= '0;
            mcs         <= '0;
            uplink_info <= '0;
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (steps == '0) begin
            state <= S_FINISH;
          end else if (scan_step) begin
            steps <= steps - SW'(1);
            if (scan_emit) begin
              if (pvalid) begin
                // an earlier grant is now known not to be the final one
                kind        <= pend.kind;
                accepted    <= 1'b0;
                grant_slot  <= pend.slot;
                grant_rnti  <= pend.rnti;
                prb_first   <= pend.pf;
                prb_count   <= pend.pc;
                mcs         <= pend.mcs;
                uplink_info <= pend.info;
                last        <= 1'b0;
              end
              pend    <= head_res;
              pvalid  <= 1'b1;
              emitted <= emitted + MAXC_W'(1);
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            // held grant closes the burst; with none, a bare status result
            accepted    <= 1'b0;
            last        <= 1'b1;
            kind        <= pvalid ? pend.kind : KIND_STATUS;
            grant_slot  <= pvalid ? pend.slot : '0;
            grant_rnti  <= pvalid ? pend.rnti : '0;
            prb_first   <= pvalid ? pend.pf   : '0;
            prb_count   <= pvalid ? pend.pc   : '0;
            mcs         <= pvalid ? pend.mcs  : '0;
            uplink_info <= pvalid ? pend.info : '0;
            pvalid      <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // held grant exists only while a pop is under way
  a_pend_in_pop: assert property (@(posedge clk) disable iff (rst)
    pvalid |-> (state == S_SCAN || state == S_FINISH))
    else $error("held grant outside a pop");

  // a pop never emits more than the clamped count
  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (emitted <= maxc))
    else $error("pop emitted past max_count");

  // an emitted grant never overwrites an output still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (scan_emit && pvalid) |-> out_free)
    else $error("result overwritten while stalled");

  // downlink queue never grows past its depth
  a_dl_bound: assert property (@(posedge clk) disable iff (rst)
    dl_ctl.push |-> !dl_full)
    else $error("downlink push into full table");
`endif

endmodule
`default_nettype wire
